/* design/itoa_pkg.sv */
// package: shared types, codes and character helpers for the integer to ascii formatter
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 64;

    localparam logic [2:0] KIND_UDEC = 3'd0;
    localparam logic [2:0] KIND_SDEC = 3'd1;
    localparam logic [2:0] KIND_LHEX = 3'd2;
    localparam logic [2:0] KIND_UHEX = 3'd3;
    localparam logic [2:0] KIND_PTR  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_PREFIX,
        ST_DIGITS
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } pfx_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD_HEX,
        CMD_LOAD_DEC,
        CMD_DABBLE,
        CMD_SHIFT
    } cmd_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] r;
        begin
            if (d < 4'd10)
                r = 8'h30 + {4'h0, d};
            else if (upper)
                r = 8'h37 + {4'h0, d};
            else
                r = 8'h57 + {4'h0, d};
            return r;
        end
    endfunction

    function automatic logic [7:0] prefix_char(input pfx_t p, input logic [2:0] idx);
        logic [7:0] r;
        begin
            r = 8'h30;
            case (p)
                PFX_MINUS: r = 8'h2d;
                PFX_HEX:   r = (idx == 3'd0) ? 8'h30 : 8'h78;
                PFX_NIL:
                begin
                    case (idx)
                        3'd0:    r = 8'h28;
                        3'd1:    r = 8'h6e;
                        3'd2:    r = 8'h69;
                        3'd3:    r = 8'h6c;
                        default: r = 8'h29;
                    endcase
                end
                default:   r = 8'h30;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] prefix_last_idx(input pfx_t p);
        logic [2:0] r;
        begin
            case (p)
                PFX_NIL: r = 3'd4;
                PFX_HEX: r = 3'd1;
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/itoa_if.sv */
// interfaces: number request channel and character request channel
interface itoa_num_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [63:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface itoa_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

/* design/integer_to_ascii_formatter_core.sv */
// top level: integer to ascii formatter (decimal, signed decimal, hex, pointer)
//
// Takes one number request (kind, value) and returns its text as character
// requests, most significant first, last set on the final one. Kinds: 0
// unsigned decimal, 1 signed decimal (leading '-'), 2 lower hex, 3 upper hex,
// 4 pointer ("0x" plus lower hex, "(nil)" for zero); codes 5 to 7 act as
// unsigned decimal. Only the low VALUE_BITS bits of value are used. One number
// is worked on at a time and number.ready is high only while the sequencer
// is idle. A decimal number first goes through the bit-serial double-dabble
// pass of the shared digit register, hex skips that pass; after it, leading
// zero digits are stripped (up to NDIG-1, NDIG = 20 at the default) and the
// first digit is seen, then one character is emitted per cycle while the
// text side keeps taking them, any prefix ('-' or "0x") first. The sequencer
// then returns to idle before it takes the next number. The last character
// of one number may still sit in the output register while the next number
// is accepted.
module integer_to_ascii_formatter_core #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    itoa_num_if.sink     number,
    itoa_char_if.source  text
);

    // decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    itoa_pkg::state_t state_reg, state_next;
    itoa_pkg::pfx_t   pfx_reg, pfx_next;
    logic             upper_reg, upper_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       pidx_reg, pidx_next;

    // output register parts the text side from the sequencer
    logic             ovalid_reg;
    logic [7:0]       ochar_reg;
    logic             olast_reg;

    logic                  out_free;
    logic                  emit;
    logic [7:0]            emit_char;
    logic                  emit_last;
    itoa_pkg::cmd_t        cmd;
    logic [3:0]            top_digit;

    // accepted number decode
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  is_hex;
    logic                  is_ptr;
    logic                  is_zero;

    assign out_free = !ovalid_reg || text.ready;

    assign v       = number.value[VALUE_BITS-1:0];
    assign is_ptr  = (number.kind == itoa_pkg::KIND_PTR);
    assign is_hex  = is_ptr || (number.kind == itoa_pkg::KIND_LHEX)
                     || (number.kind == itoa_pkg::KIND_UHEX);
    assign neg     = (number.kind == itoa_pkg::KIND_SDEC) && v[VALUE_BITS-1];
    // most negative value wraps to its own unsigned magnitude
    assign mag     = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
    assign is_zero = (v == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        pfx_next   = pfx_reg;
        upper_next = upper_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (number.valid)
                begin
                    upper_next = (number.kind == itoa_pkg::KIND_UHEX);
                    pidx_next  = 3'd0;
                    if (is_ptr && is_zero)
                    begin
                        pfx_next   = itoa_pkg::PFX_NIL;
                        state_next = itoa_pkg::ST_PREFIX;
                    end
                    else if (is_hex)
                    begin
                        pfx_next   = is_ptr ? itoa_pkg::PFX_HEX : itoa_pkg::PFX_NONE;
                        cnt_next   = CNT_W'(NDIG);
                        state_next = itoa_pkg::ST_STRIP;
                    end
                    else
                    begin
                        pfx_next   = neg ? itoa_pkg::PFX_MINUS : itoa_pkg::PFX_NONE;
                        cnt_next   = CNT_W'(VALUE_BITS);
                        state_next = itoa_pkg::ST_CONV;
                    end
                end
            end
            itoa_pkg::ST_CONV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(NDIG);
                    state_next = itoa_pkg::ST_STRIP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            itoa_pkg::ST_STRIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'h0 && cnt_reg != CNT_W'(1))
                    cnt_next = cnt_reg - CNT_W'(1);
                else if (pfx_reg == itoa_pkg::PFX_NONE)
                    state_next = itoa_pkg::ST_DIGITS;
                else
                    state_next = itoa_pkg::ST_PREFIX;
            end
            itoa_pkg::ST_PREFIX:
            begin
                if (out_free)
                begin
                    pidx_next = pidx_reg + 3'd1;
                    if (pidx_reg == itoa_pkg::prefix_last_idx(pfx_reg))
                    begin
                        if (pfx_reg == itoa_pkg::PFX_NIL)
                            state_next = itoa_pkg::ST_IDLE;
                        else
                            state_next = itoa_pkg::ST_DIGITS;
                    end
                end
            end
            itoa_pkg::ST_DIGITS:
            begin
                if (out_free)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd       = itoa_pkg::CMD_HOLD;
        emit      = 1'b0;
        emit_char = 8'h30;
        emit_last = 1'b0;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (number.valid && !(is_ptr && is_zero))
                    cmd = is_hex ? itoa_pkg::CMD_LOAD_HEX : itoa_pkg::CMD_LOAD_DEC;
            end
            itoa_pkg::ST_CONV:
            begin
                cmd = itoa_pkg::CMD_DABBLE;
            end
            itoa_pkg::ST_STRIP:
            begin
                if (top_digit == 4'h0 && cnt_reg != CNT_W'(1))
                    cmd = itoa_pkg::CMD_SHIFT;
            end
            itoa_pkg::ST_PREFIX:
            begin
                emit      = out_free;
                emit_char = itoa_pkg::prefix_char(pfx_reg, pidx_reg);
                emit_last = (pfx_reg == itoa_pkg::PFX_NIL)
                            && (pidx_reg == itoa_pkg::prefix_last_idx(pfx_reg));
            end
            itoa_pkg::ST_DIGITS:
            begin
                emit      = out_free;
                emit_char = itoa_pkg::digit_char(top_digit, upper_reg);
                emit_last = (cnt_reg == CNT_W'(1));
                if (out_free)
                    cmd = itoa_pkg::CMD_SHIFT;
            end
            default:
            begin
                cmd = itoa_pkg::CMD_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itoa_pkg::ST_IDLE;
            pfx_reg    <= itoa_pkg::PFX_NONE;
            upper_reg  <= 1'b0;
            cnt_reg    <= '0;
            pidx_reg   <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pfx_reg   <= pfx_next;
            upper_reg <= upper_next;
            cnt_reg   <= cnt_next;
            pidx_reg  <= pidx_next;
            if (emit)
                ovalid_reg <= 1'b1;
            else if (text.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // character payload, loaded only when a new request goes out
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ochar_reg <= emit_char;
            olast_reg <= emit_last;
        end
    end

    itoa_digits #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_value (mag),
        .top_digit  (top_digit)
    );

    assign number.ready  = (state_reg == itoa_pkg::ST_IDLE);
    assign text.valid    = ovalid_reg;
    assign text.out_char = ochar_reg;
    assign text.last     = olast_reg;

endmodule

/* design/itoa_digits.sv */
// digit register with shared double-dabble step, hex load and digit shift
module itoa_digits #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int NDIG       = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  itoa_pkg::cmd_t        cmd,
    input  logic [VALUE_BITS-1:0] load_value,
    output logic [3:0]            top_digit
);

    localparam int BCD_W = NDIG * 4;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      adj;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        case (cmd)
            itoa_pkg::CMD_LOAD_HEX:
            begin
                bcd_next = '0;
                bcd_next[VALUE_BITS-1:0] = load_value;
            end
            itoa_pkg::CMD_LOAD_DEC:
            begin
                bin_next = load_value;
                bcd_next = '0;
            end
            itoa_pkg::CMD_DABBLE:
            begin
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            end
            itoa_pkg::CMD_SHIFT:
            begin
                bcd_next = {bcd_reg[BCD_W-5:0], 4'h0};
            end
            default:
            begin
                bin_next = bin_reg;
                bcd_next = bcd_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
            bcd_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

/* design/itoa_checker.sv */
// checker: port-level properties of the formatter, bound to the top level
module itoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    // a stalled character request stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("character request dropped while stalled");

    // no new number while a number is being worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("number accepted back to back");

    // a character before the last one means the number is still in progress
    a_mid_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready in the middle of a text");

    // every character is printable text, never a null byte
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_char != 8'h00)
        else $error("null character emitted");

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.out_char),
    .out_last  (text.last)
);

/* verif/integer_to_ascii_formatter_core_test.sv */
// testbench: random and directed number requests checked character by character
class char_scoreboard;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t pending_chars[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction

    // builds the text of one accepted number and queues it, last flag on the final char
    function void note_number(input logic [2:0] kind, input logic [63:0] value);
        logic [7:0]  txt[$];
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] d;
        logic [7:0]  c;
        bit          upper;
        int          start;
        text_char_t  entry;
        mag = value;
        radix = 64'd10;
        upper = 1'b0;
        if (kind == itoa_pkg::KIND_PTR && value == 64'd0)
        begin
            txt.push_back("(");
            txt.push_back("n");
            txt.push_back("i");
            txt.push_back("l");
            txt.push_back(")");
        end
        else
        begin
            case (kind)
                itoa_pkg::KIND_PTR:
                begin
                    txt.push_back("0");
                    txt.push_back("x");
                    radix = 64'd16;
                end
                itoa_pkg::KIND_LHEX: radix = 64'd16;
                itoa_pkg::KIND_UHEX:
                begin
                    radix = 64'd16;
                    upper = 1'b1;
                end
                itoa_pkg::KIND_SDEC:
                begin
                    if (value[63])
                    begin
                        txt.push_back("-");
                        mag = 64'd0 - value;
                    end
                end
                default: radix = 64'd10;
            endcase
            start = txt.size();
            do
            begin
                d = mag % radix;
                if (d < 64'd10)
                    c = "0" + d[7:0];
                else
                    c = (upper ? "A" : "a") + d[7:0] - 8'd10;
                txt.insert(start, c);
                mag = mag / radix;
            end
            while (mag != 64'd0);
        end
        foreach (txt[i])
        begin
            entry.ch = txt[i];
            entry.last = (i == txt.size() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    function void check_char(input logic [7:0] ch, input logic last);
        text_char_t want;
        if (pending_chars.size() == 0)
        begin
            $error("out_char: expected none actual %h (last %b)", ch, last);
            errors++;
            return;
        end
        want = pending_chars.pop_front();
        if (ch !== want.ch)
        begin
            $error("out_char: expected %h actual %h", want.ch, ch);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %b actual %b", want.last, last);
            errors++;
        end
    endfunction

endclass

module integer_to_ascii_formatter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // kind codes with no format of their own, they fall back to unsigned decimal
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    localparam int RANDOM_NUMBERS = 187;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT        = 1500;
    localparam int DRAIN_CYCLES   = 150;

    logic clk;
    logic rst_n;

    itoa_num_if  number();
    itoa_char_if text();

    char_scoreboard sb = new();
    int numbers_sent = 0;

    integer_to_ascii_formatter_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .text   (text)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short idle gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [2:0] pick_kind();
        if ($urandom_range(0, 9) == 0)
            return 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        else
            return 3'($urandom_range(itoa_pkg::KIND_UDEC, itoa_pkg::KIND_PTR));
    endfunction

    // value mix: full width, shortened, small, around powers of ten, small negatives,
    // single bits and runs of ones
    function automatic logic [63:0] pick_value();
        logic [63:0] full;
        logic [63:0] p10;
        int          r;
        int          n;
        full = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 30)
            return full;
        else if (r < 55)
            return full >> $urandom_range(1, 63);
        else if (r < 68)
            return 64'($urandom_range(0, 1000));
        else if (r < 80)
        begin
            p10 = 64'd1;
            n = $urandom_range(0, 19);
            repeat (n) p10 = p10 * 64'd10;
            return p10 - 64'($urandom_range(0, 1));
        end
        else if (r < 90)
            return ~64'($urandom_range(0, 1000));
        else if ($urandom_range(0, 1) == 1)
            return 64'd1 << $urandom_range(0, 63);
        else
            return ~64'd0 >> $urandom_range(0, 63);
    endfunction

    // offer one number, hold it until taken, then maybe leave a gap;
    // called at a rising edge and returns at one
    task automatic send_number(input logic [2:0] kind, input logic [63:0] value);
        int gap;
        number.valid <= 1'b1;
        number.kind  <= kind;
        number.value <= value;
        @(posedge clk);
        while (!number.ready)
            @(posedge clk);
        sb.note_number(kind, value);
        numbers_sent++;
        // gaps only in every other stretch of 30 numbers, back to back otherwise
        gap = 0;
        if ((numbers_sent / 30) % 2 == 1 && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap != 0)
        begin
            // junk on the payload while valid is low
            number.valid <= 1'b0;
            number.kind  <= 3'($urandom);
            number.value <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
    endtask

    // number side: reset, directed cases, random numbers, drain, verdict
    initial
    begin : stimulus
        int i;
        logic [2:0] k;
        rst_n        <= 1'b0;
        number.valid <= 1'b0;
        number.kind  <= itoa_pkg::KIND_UDEC;
        number.value <= 64'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero in every format, pointer zero gives the nil text
        send_number(itoa_pkg::KIND_UDEC, 64'd0);
        send_number(itoa_pkg::KIND_SDEC, 64'd0);
        send_number(itoa_pkg::KIND_LHEX, 64'd0);
        send_number(itoa_pkg::KIND_UHEX, 64'd0);
        send_number(itoa_pkg::KIND_PTR,  64'd0);
        // widest decimal text and digit count edges
        send_number(itoa_pkg::KIND_UDEC, ~64'd0);
        send_number(itoa_pkg::KIND_UDEC, 64'd10000000000000000000);
        send_number(itoa_pkg::KIND_UDEC, 64'd9);
        // signed: minus one, most negative, most positive, small negative
        send_number(itoa_pkg::KIND_SDEC, ~64'd0);
        send_number(itoa_pkg::KIND_SDEC, 64'h8000_0000_0000_0000);
        send_number(itoa_pkg::KIND_SDEC, 64'h7fff_ffff_ffff_ffff);
        send_number(itoa_pkg::KIND_SDEC, 64'd0 - 64'd10);
        // hex in both cases, every digit value
        send_number(itoa_pkg::KIND_LHEX, 64'hfedc_ba98_7654_3210);
        send_number(itoa_pkg::KIND_UHEX, 64'hfedc_ba98_7654_3210);
        send_number(itoa_pkg::KIND_UHEX, 64'ha);
        send_number(itoa_pkg::KIND_LHEX, ~64'd0);
        // nonzero pointers get the 0x prefix
        send_number(itoa_pkg::KIND_PTR, 64'd1);
        send_number(itoa_pkg::KIND_PTR, ~64'd0);
        send_number(itoa_pkg::KIND_PTR, 64'hdead_beef);
        // spare kind codes behave as unsigned decimal
        send_number(KIND_SPARE_LO, 64'd0);
        send_number(KIND_SPARE_MID, 64'd12345);
        send_number(KIND_SPARE_HI, ~64'd0);
        send_number(KIND_SPARE_HI, 64'h8000_0000_0000_0000);

        for (i = 0; i < RANDOM_NUMBERS; i++)
        begin
            k = pick_kind();
            send_number(k, pick_value());
        end
        number.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        // catch any stray characters after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // text side: random stalls start only in two of every three windows,
    // plus one long hold that backs the block up into the number side
    initial
    begin : char_sink
        int stall_left;
        int cycle_no;
        bit held;
        stall_left = 0;
        cycle_no = 0;
        held = 1'b0;
        text.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (!held && cycle_no >= HOLD_AT)
            begin
                held = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0)
            begin
                text.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                text.ready <= 1'b1;
                if ((cycle_no / 500) % 3 != 0 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // every character request taken is checked against the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && text.valid && text.ready)
            sb.check_char(text.out_char, text.last);
    end

    // ends the run if neither side moves for too long
    always @(posedge clk)
    begin : watchdog
        int idle;
        if (!rst_n || (number.valid && number.ready) || (text.valid && text.ready))
            idle = 0;
        else
        begin
            idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
